@@ rtl/core/bpa_pkg.sv @@
// -----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared types, command codes and default sizes for the page allocator.
// -----------------------------------------------------------------------------
package bpa_pkg;

   // Width of the page index fields on the request and response ports.
   localparam int PAGE_FIELD_W = 12;

   // Default number of pages and width of one bitmap word.
   localparam int DEF_NUM_PAGES = 4096;
   localparam int DEF_WORD_BITS = 64;

   // Command codes.
   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]              command;
      logic [PAGE_FIELD_W-1:0] page_index;
   } bpa_req_type;

   typedef struct packed {
      logic                    ok;
      logic [PAGE_FIELD_W-1:0] allocated_page;
      logic                    page_free;
   } bpa_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE,
      ST_SCAN
   } bpa_state_type;

endpackage

@@ rtl/core/bpa_ram.sv @@
// -----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write port and one read port; read data is registered.
// -----------------------------------------------------------------------------
module bpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/core/bitmap_page_allocator.sv @@
// -----------------------------------------------------------------------------
// Bitmap page allocator
// Responses: a rejected or unknown request answers in the cycle after acceptance;
// a free, a query or an allocate that fills the store answers through the fetch
// and update states; any other allocate answers after a further word-by-word
// scan of the bitmap RAM through its single read port.
// Throughput: one request at a time; busy drops as the response goes out, so the
// next request can be taken at the edge that takes the response.
// Reset: a clearing pass writes zero to every bitmap word, with busy high; the
// receiver cannot stall responses.
// -----------------------------------------------------------------------------
module bitmap_page_allocator
   import bpa_pkg::*;
#(
   parameter int NUM_PAGES = DEF_NUM_PAGES,
   // Must be a power of two.
   parameter int WORD_BITS = DEF_WORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  bpa_req_type req_data,
   output logic        rsp_strobe,
   output bpa_rsp_type rsp_data
);

   // Sizes derived from the page count and the word width. The bitmap is held
   // as ROWS words of WORD_BITS bits; bits past NUM_PAGES in the last word are
   // padding and are treated as permanently used during the scan.
   localparam int ROWS      = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int HINT_W    = $clog2(NUM_PAGES + 1);
   localparam int LAST_BITS = NUM_PAGES - (ROWS - 1) * WORD_BITS;

   localparam logic [ROW_W-1:0]     LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [HINT_W-1:0]    PAGES_MAX = HINT_W'(NUM_PAGES);
   localparam logic [HINT_W-1:0]    COUNT_TOP = HINT_W'(NUM_PAGES - 1);
   localparam logic [WORD_BITS-1:0] PAD_MASK  =
      ~((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));

   function automatic logic [ROW_W-1:0] row_of(input logic [HINT_W-1:0] p);
      row_of = ROW_W'(p / WORD_BITS);
   endfunction

   function automatic logic [BIT_W-1:0] bit_of(input logic [HINT_W-1:0] p);
      bit_of = BIT_W'(p % WORD_BITS);
   endfunction

   // Position of the lowest set bit: isolate it with v & -v, then encode.
   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [WORD_BITS-1:0] iso;
      logic [BIT_W-1:0]     pos;
      iso = v & (~v + WORD_BITS'(1));
      pos = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (iso[i]) begin
            pos = pos | BIT_W'(i);
         end
      end
      lowest_set = pos;
   endfunction

   // Sequencer and datapath registers.
   bpa_state_type     state_ff, state_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [HINT_W-1:0] op_page_ff, op_page_in;
   logic [HINT_W-1:0] used_count_ff, used_count_in;
   logic [HINT_W-1:0] free_hint_ff, free_hint_in;
   logic [ROW_W-1:0]  scan_row_ff, scan_row_in;
   logic [ROW_W-1:0]  chk_row_ff, chk_row_in;
   logic              chk_valid_ff, chk_valid_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   bpa_rsp_type       rsp_data_ff, rsp_data_in;

   // Bitmap RAM signals.
   logic                 ram_we;
   logic [ROW_W-1:0]     ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [ROW_W-1:0]     ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   // Shared decode.
   logic                 accept;
   logic                 alloc_can;
   logic                 in_range;
   logic                 cur_bit;
   logic [WORD_BITS-1:0] op_onehot;
   logic [WORD_BITS-1:0] scan_word;
   logic                 found_free;
   logic [BIT_W-1:0]     zero_pos;

   bpa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ROWS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign accept    = start && !busy;
   assign alloc_can = (used_count_ff < PAGES_MAX) && (free_hint_ff < PAGES_MAX);
   assign in_range  = (32'(req_data.page_index) < 32'(NUM_PAGES));
   assign op_onehot = WORD_BITS'(1) << bit_of(op_page_ff);
   assign cur_bit   = ram_rd_data[bit_of(op_page_ff)];

   // During the scan the padding bits of the last word count as used.
   assign scan_word  = ram_rd_data | ((chk_row_ff == LAST_ROW) ? PAD_MASK : '0);
   assign found_free = (~scan_word != '0);
   assign zero_pos   = lowest_set(~scan_word);

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (scan_row_ff == LAST_ROW) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  CMD_ALLOC: state_in = alloc_can ? ST_FETCH : ST_IDLE;
                  CMD_FREE:  state_in = in_range ? ST_FETCH : ST_IDLE;
                  CMD_QUERY: state_in = in_range ? ST_FETCH : ST_IDLE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (cmd_ff == CMD_ALLOC && used_count_ff != COUNT_TOP) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (chk_valid_ff && found_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, RAM control and response.
   always_comb begin
      cmd_in        = cmd_ff;
      op_page_in    = op_page_ff;
      used_count_in = used_count_ff;
      free_hint_in  = free_hint_ff;
      scan_row_in   = scan_row_ff;
      chk_row_in    = chk_row_ff;
      chk_valid_in  = chk_valid_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      ram_we        = 1'b0;
      ram_wr_addr   = row_of(op_page_ff);
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = row_of(op_page_ff);

      case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_wr_addr = scan_row_ff;
            ram_wr_data = '0;
            scan_row_in = scan_row_ff + ROW_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_data.command;
               if (req_data.command == CMD_ALLOC) begin
                  op_page_in = free_hint_ff;
               end else begin
                  op_page_in = HINT_W'(req_data.page_index);
               end
               // Requests that need no bitmap access answer at once.
               case (req_data.command)
                  CMD_ALLOC: rsp_strobe_in = !alloc_can;
                  CMD_FREE:  rsp_strobe_in = !in_range;
                  CMD_QUERY: begin
                     rsp_strobe_in  = !in_range;
                     rsp_data_in.ok = 1'b1;
                  end
                  default:   rsp_strobe_in = 1'b1;
               endcase
            end
         end
         ST_FETCH: begin
            // Read address is the row of the operand page; data arrives next.
         end
         ST_UPDATE: begin
            case (cmd_ff)
               CMD_ALLOC: begin
                  ram_we        = 1'b1;
                  ram_wr_data   = ram_rd_data | op_onehot;
                  used_count_in = used_count_ff + HINT_W'(1);
                  if (used_count_ff == COUNT_TOP) begin
                     // The store is now full, so no free page is left to hint.
                     free_hint_in               = PAGES_MAX;
                     rsp_strobe_in              = 1'b1;
                     rsp_data_in.ok             = 1'b1;
                     rsp_data_in.allocated_page = PAGE_FIELD_W'(op_page_ff);
                  end else begin
                     scan_row_in  = '0;
                     chk_valid_in = 1'b0;
                  end
               end
               CMD_FREE: begin
                  rsp_strobe_in = 1'b1;
                  if (cur_bit) begin
                     ram_we         = 1'b1;
                     ram_wr_data    = ram_rd_data & ~op_onehot;
                     free_hint_in   = op_page_ff;
                     rsp_data_in.ok = 1'b1;
                     if (used_count_ff != '0) begin
                        used_count_in = used_count_ff - HINT_W'(1);
                     end
                  end
               end
               CMD_QUERY: begin
                  rsp_strobe_in         = 1'b1;
                  rsp_data_in.ok        = 1'b1;
                  rsp_data_in.page_free = !cur_bit;
               end
               default: begin
                  rsp_strobe_in = 1'b1;
               end
            endcase
         end
         ST_SCAN: begin
            // Issue one row per cycle and check the row read the cycle before.
            ram_rd_addr  = scan_row_ff;
            chk_row_in   = scan_row_ff;
            chk_valid_in = 1'b1;
            if (scan_row_ff != LAST_ROW) begin
               scan_row_in = scan_row_ff + ROW_W'(1);
            end
            if (chk_valid_ff && found_free) begin
               free_hint_in               = HINT_W'({chk_row_ff, zero_pos});
               chk_valid_in               = 1'b0;
               rsp_strobe_in              = 1'b1;
               rsp_data_in.ok             = 1'b1;
               rsp_data_in.allocated_page = PAGE_FIELD_W'(op_page_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         used_count_ff <= '0;
         free_hint_ff  <= '0;
         scan_row_ff   <= '0;
         chk_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_count_ff <= used_count_in;
         free_hint_ff  <= free_hint_in;
         scan_row_ff   <= scan_row_in;
         chk_valid_ff  <= chk_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      op_page_ff  <= op_page_in;
      chk_row_ff  <= chk_row_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // The used count can never pass the number of pages.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= PAGES_MAX)
      else $error("used page count exceeds page total");

   // A scan only runs while at least one page is free.
   a_scan_has_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (used_count_ff < PAGES_MAX))
      else $error("bitmap scan started with a full store");

   // The scan must find a free page no later than the last row.
   a_scan_finds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && chk_valid_ff && chk_row_ff == LAST_ROW) |-> found_free)
      else $error("bitmap scan ran past the last row");

   // A nonzero allocated page is only reported on success.
   a_alloc_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.allocated_page != '0) |-> rsp_data.ok)
      else $error("allocated page reported on a failed request");

   // Every response follows a completed update, scan or an accepted request.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_IDLE || $past(state_ff) == ST_UPDATE
                      || $past(state_ff) == ST_SCAN))
      else $error("response strobe from an unexpected sequencer state");
`endif

endmodule

@@ dv/tb.sv @@
// -----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives allocate, free, query and unused command requests into the allocator
// and checks every response against a behavioral copy of the page bitmap, the
// used-page count and the free-page hint kept inside this testbench.
// -----------------------------------------------------------------------------
module tb;
   import bpa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PAGES = DEF_NUM_PAGES;

   // Command code 3 has no meaning; the block must answer it with all fields zero.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // A successful allocate may scan every bitmap row (64 rows plus overhead),
   // so a quiet spell as long as the watchdog limit can only mean a hang.
   localparam int WATCHDOG_LIMIT = 2000;
   // Cycles allowed after the last response for any stray strobe to show up.
   localparam int SETTLE_CYCLES = 80;
   // Keep the log short if the block is badly broken.
   localparam int MAX_REPORTED = 40;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   bpa_req_type req_data;
   logic        rsp_strobe;
   bpa_rsp_type rsp_data;

   // Predicted allocator state, updated at the edge that accepts each request.
   bit page_used [NUM_PAGES];
   int used_count = 0;
   int free_hint = 0;

   bpa_rsp_type expected_rsp_q [$];

   int error_count = 0;
   int sender_idle_pct = 0;
   int requests_sent = 0;
   int responses_checked = 0;
   int pages_granted = 0;
   int peak_used = 0;

   bitmap_page_allocator #(
      .NUM_PAGES(NUM_PAGES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Prints one line per mismatch (up to a cap) and counts every one of them.
   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < MAX_REPORTED)
         $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Applies one request to the predicted state and returns the response the
   // allocator must produce for it.
   function automatic bpa_rsp_type apply_page_request(input bpa_req_type req);
      bpa_rsp_type rsp;
      rsp = '0;
      case (req.command)
         CMD_ALLOC: begin
            // Both a full store and a hint past the end reject the request.
            if (used_count < NUM_PAGES && free_hint < NUM_PAGES) begin
               rsp.ok = 1'b1;
               rsp.allocated_page = PAGE_FIELD_W'(free_hint);
               page_used[free_hint] = 1'b1;
               used_count++;
               pages_granted++;
               if (used_count > peak_used)
                  peak_used = used_count;
               // The new hint is the lowest free page, or the end when none is left.
               free_hint = NUM_PAGES;
               if (used_count < NUM_PAGES) begin
                  for (int p = 0; p < NUM_PAGES; p++) begin
                     if (!page_used[p]) begin
                        free_hint = p;
                        break;
                     end
                  end
               end
            end
         end
         CMD_FREE: begin
            // Freeing a page that is already free is rejected and changes nothing.
            if (page_used[req.page_index]) begin
               page_used[req.page_index] = 1'b0;
               if (used_count > 0)
                  used_count--;
               free_hint = req.page_index;
               rsp.ok = 1'b1;
            end
         end
         CMD_QUERY: begin
            rsp.ok = 1'b1;
            rsp.page_free = !page_used[req.page_index];
         end
         default: ;
      endcase
      return rsp;
   endfunction

   // Returns a page that is currently in use, starting the search at a random
   // point, or a random page when nothing is in use.
   function automatic logic [PAGE_FIELD_W-1:0] pick_used_page();
      int base;
      base = $urandom_range(NUM_PAGES - 1);
      for (int k = 0; k < NUM_PAGES; k++) begin
         if (page_used[(base + k) % NUM_PAGES])
            return PAGE_FIELD_W'((base + k) % NUM_PAGES);
      end
      return PAGE_FIELD_W'(base);
   endfunction

   // Sends one request. Inputs change on the falling edge, and each cycle the
   // sender may idle with the current idle percentage; the request is accepted
   // at the first rising edge where busy is low. Start stays high after
   // acceptance only until the next falling edge, where the next call either
   // drives a new request or idles, so the request is never taken twice.
   task automatic send_request(input logic [1:0] command,
                               input logic [PAGE_FIELD_W-1:0] page);
      bpa_req_type req;
      req.command = command;
      req.page_index = page;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= req;
      do
         @(posedge clock);
      while (busy);
      expected_rsp_q.push_back(apply_page_request(req));
      requests_sent++;
   endtask

   // Walks every command through its normal case, and a free through rejection, on a
   // nearly empty bitmap, including hint reuse after a free and an out-of-order hint.
   task automatic test_directed_commands();
      send_request(CMD_QUERY, 12'd0);
      send_request(CMD_QUERY, 12'hFFF);
      // The page index is ignored for an allocate; the first grant is page 0.
      send_request(CMD_ALLOC, 12'hFFF);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_ALLOC, 12'hAAA);
      send_request(CMD_QUERY, 12'd1);
      // A freed page becomes the hint, and a second free of it is rejected.
      send_request(CMD_FREE, 12'd1);
      send_request(CMD_FREE, 12'd1);
      send_request(CMD_FREE, 12'hFFF);
      send_request(CMD_ALLOC, 12'h555);
      // Free two pages so that the hint points above the lowest free page.
      send_request(CMD_FREE, 12'd0);
      send_request(CMD_FREE, 12'd2);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_UNUSED, 12'd0);
      send_request(CMD_UNUSED, 12'hFFF);
      send_request(CMD_QUERY, 12'hAAA);
      send_request(CMD_QUERY, 12'h555);
      send_request(CMD_FREE, 12'hAAA);
      send_request(CMD_ALLOC, 12'd0);
   endtask

   // Allocates a block of low pages, then frees pages in a scattered order so
   // later traffic sees a fragmented map and scans that stop in several rows.
   task automatic test_alloc_and_scatter();
      logic [PAGE_FIELD_W-1:0] page;
      for (int i = 0; i < 100; i++)
         send_request(CMD_ALLOC, PAGE_FIELD_W'($urandom));
      // An odd stride visits the pages in a scattered but non-repeating order.
      for (int i = 0; i < 80; i++) begin
         page = PAGE_FIELD_W'((i * 37) % 128);
         send_request(CMD_FREE, page);
      end
   endtask

   // Random mix of requests. Most frees and half the queries target pages that
   // are in use, so they succeed and keep the map churning; the rest hit
   // random pages and exercise the rejection paths.
   task automatic test_random_traffic(input int count);
      int pick;
      logic [1:0] command;
      logic [PAGE_FIELD_W-1:0] page;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         page = PAGE_FIELD_W'($urandom);
         if (pick < 40) begin
            command = CMD_ALLOC;
         end else if (pick < 75) begin
            command = CMD_FREE;
            if ($urandom_range(99) < 80)
               page = pick_used_page();
         end else if (pick < 95) begin
            command = CMD_QUERY;
            if ($urandom_range(1) == 1)
               page = pick_used_page();
         end else begin
            command = CMD_UNUSED;
         end
         send_request(command, page);
      end
   endtask

   // Each response is compared field by field with the oldest expectation.
   // Outputs are sampled at the rising edge, before the block updates them.
   always @(posedge clock) begin : check_responses
      bpa_rsp_type want;
      if (rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("response with no request pending", int'(rsp_data), 0);
         end else begin
            want = expected_rsp_q.pop_front();
            responses_checked++;
            if (rsp_data.ok !== want.ok)
               report_mismatch("ok", int'(rsp_data.ok), int'(want.ok));
            if (rsp_data.allocated_page !== want.allocated_page)
               report_mismatch("allocated_page", int'(rsp_data.allocated_page),
                               int'(want.allocated_page));
            if (rsp_data.page_free !== want.page_free)
               report_mismatch("page_free", int'(rsp_data.page_free),
                               int'(want.page_free));
         end
      end
   end

   // Ends the run if neither a request nor a response moves for too long. This
   // also catches responses that never arrive at the end of the run.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("ERROR: no progress for %0d cycles, %0d responses outstanding",
               WATCHDOG_LIMIT, expected_rsp_q.size());
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // The block clears its bitmap after reset with busy high; the first
      // request simply waits for busy to drop.
      sender_idle_pct = 7;
      test_directed_commands();
      test_random_traffic(230);
      test_alloc_and_scatter();
      sender_idle_pct = 51;
      test_random_traffic(230);
      sender_idle_pct = 0;
      test_random_traffic(230);

      @(negedge clock);
      start <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses; %0d pages granted, %0d in use",
               requests_sent, responses_checked, pages_granted, used_count);
      $display("At most %0d pages were in use at once, with a fragmented map; %0d mismatches",
               peak_used, error_count);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ bitmap_page_allocator.f @@
rtl/core/bpa_pkg.sv
rtl/core/bpa_ram.sv
rtl/core/bitmap_page_allocator.sv
dv/tb.sv
